>>> design/ebsc_pkg.sv
// Shared types and byte constants for the escape byte-stuffing codec.
package ebsc_pkg;

  // Escape and substitute byte codes.
  localparam logic [7:0] ESC_BYTE = 8'hEF;
  localparam logic [7:0] ESC_SUB  = 8'hEA;
  localparam logic [7:0] SUB_BYTE = 8'h1A;
  localparam logic [7:0] ESC_1B   = 8'hEB;
  localparam logic [7:0] BYTE_1B  = 8'h1B;

  // Values of the direction register.
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // Input beat payload.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_frame_end;
  } ebsc_in_t;

  // Output beat payload.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       out_frame_end;
  } ebsc_out_t;

  // Summary of one coded item, passed from the core to the output buffer.
  typedef struct packed {
    logic [1:0] cnt;
    logic       pending_nxt;
  } ebsc_res_t;

endpackage

>>> design/ebsc_core.sv
// Combinational encode/decode mapping of one input byte into up to two output beats.
module ebsc_core
  import ebsc_pkg::*;
(
  input  logic      direction,
  input  logic      pending,
  input  ebsc_in_t  item,
  output ebsc_res_t res,
  output ebsc_out_t beat0,
  output ebsc_out_t beat1
);

  logic [7:0] b;
  logic       fend;

  assign b    = item.in_byte;
  assign fend = item.in_frame_end;

  // Work out how many beats this byte gives and what they carry.
  always_comb begin
    res.cnt         = 2'd1;
    res.pending_nxt = 1'b0;
    beat0           = '{out_byte: b, run_last: 1'b1, out_frame_end: fend};
    beat1           = '{out_byte: b, run_last: 1'b1, out_frame_end: fend};
    if (direction == DIR_ENCODE) begin
      // Escape the three special bytes as a two-beat pair.
      priority if (b == SUB_BYTE) begin
        res.cnt        = 2'd2;
        beat0          = '{out_byte: ESC_BYTE, run_last: 1'b0, out_frame_end: 1'b0};
        beat1.out_byte = ESC_SUB;
      end else if (b == ESC_BYTE) begin
        res.cnt        = 2'd2;
        beat0          = '{out_byte: ESC_BYTE, run_last: 1'b0, out_frame_end: 1'b0};
        beat1.out_byte = ESC_BYTE;
      end else if (b == BYTE_1B) begin
        res.cnt        = 2'd2;
        beat0          = '{out_byte: ESC_BYTE, run_last: 1'b0, out_frame_end: 1'b0};
        beat1.out_byte = ESC_1B;
      end else begin
        res.cnt = 2'd1;
      end
    end else if (pending) begin
      // A held escape either completes a pair or is flushed ahead of the byte.
      priority if (b == ESC_SUB) begin
        beat0.out_byte = SUB_BYTE;
      end else if (b == ESC_BYTE) begin
        beat0.out_byte = ESC_BYTE;
      end else if (b == ESC_1B) begin
        beat0.out_byte = BYTE_1B;
      end else begin
        res.cnt = 2'd2;
        beat0   = '{out_byte: ESC_BYTE, run_last: 1'b0, out_frame_end: 1'b0};
      end
    end else if (b == ESC_BYTE && !fend) begin
      // Hold the escape until the next byte arrives.
      res.cnt         = 2'd0;
      res.pending_nxt = 1'b1;
    end
  end

endmodule

>>> design/ebsc_outbuf.sv
// Two-entry result register that feeds the output channel one beat at a time.
module ebsc_outbuf
  import ebsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  ebsc_res_t res,
  input  ebsc_out_t beat0,
  input  ebsc_out_t beat1,
  output logic      space,
  output logic      out_valid,
  input  logic      out_ready,
  output ebsc_out_t out_data
);

  logic [1:0] cnt_r, cnt_nxt;
  ebsc_out_t  slot0_r, slot0_nxt;
  ebsc_out_t  slot1_r, slot1_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;
  assign pop       = out_valid && out_ready;
  // Room for a new item once the buffer is empty or its last beat leaves now.
  assign space     = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);

  // Next fill level and slot contents.
  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (load) begin
      cnt_nxt   = res.cnt;
      slot0_nxt = beat0;
      slot1_nxt = beat1;
    end else if (pop) begin
      cnt_nxt   = cnt_r - 2'd1;
      slot0_nxt = slot1_r;
    end
  end

  // Fill level is control state; the slots are payload only.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

>>> design/escape_byte_stuffing_codec.sv
// Top level of the escape byte-stuffing codec: mode register, escape state and output buffer.
// The codec escapes (direction 0) or unescapes (direction 1) a byte stream. Each input beat
// is coded in the cycle it is accepted and lands in a two-entry result register that drains
// one output beat per cycle while out_ready is high. A byte that gives one output beat can be
// followed by a new input beat in every such cycle; a byte that gives two output beats (an
// escape pair, or a flushed escape) holds off the next input beat until its second beat
// leaves, bounded by the single-byte output channel. A held escape gives no output beat.
// Write the direction register only while the codec is idle; every write drops a held escape.
module escape_byte_stuffing_codec
  import ebsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ebsc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ebsc_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_direction
);

  logic      direction_r, direction_nxt;
  logic      pending_r, pending_nxt;
  logic      in_fire;
  ebsc_res_t res;
  ebsc_out_t beat0;
  ebsc_out_t beat1;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  // Coding logic for the beat at the input.
  ebsc_core u_core (
    .direction (direction_r),
    .pending   (pending_r),
    .item      (in_data),
    .res       (res),
    .beat0     (beat0),
    .beat1     (beat1)
  );

  // Result register toward the output channel.
  ebsc_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .res       (res),
    .beat0     (beat0),
    .beat1     (beat1),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Mode register and held-escape flag.
  always_comb begin
    direction_nxt = direction_r;
    pending_nxt   = pending_r;
    if (cfg_valid && cfg_ready) begin
      direction_nxt = cfg_direction;
      pending_nxt   = 1'b0;
    end else if (in_fire) begin
      pending_nxt = res.pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_ENCODE;
      pending_r   <= 1'b0;
    end else begin
      direction_r <= direction_nxt;
      pending_r   <= pending_nxt;
    end
  end

`ifndef ASSERT_OFF
  // Encode mode never holds an escape.
  a_no_pending_encode: assert property (@(posedge clk) disable iff (!rst_n)
    (direction_r == DIR_ENCODE) |-> !pending_r)
    else $error("escape held in encode mode");

  // An accepted item with results always shows a beat in the next cycle.
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res.cnt != 2'd0) |=> out_valid)
    else $error("accepted item produced no output beat");

  // With nothing buffered, the input side is never stalled.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // The first beat of a two-beat result is never marked last.
  a_pair_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res.cnt == 2'd2) |=> (out_valid && !out_data.run_last))
    else $error("first beat of a pair marked last");
`endif

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the escape byte-stuffing codec, with directed and random traffic.
module tb;
  import ebsc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_SHOWN = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  ebsc_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  ebsc_out_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_direction = 1'b0;

  // Predictor state: the mode register and a held decode escape.
  logic      mode_dir;
  logic      esc_held;
  ebsc_out_t expected_beats[$];

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int fail_count = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  escape_byte_stuffing_codec u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_direction(cfg_direction)
  );

  always #6 clk = ~clk;

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The receiver stalls at random with the current stall rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  function automatic void push_beat(logic [7:0] b, logic last, logic fend);
    ebsc_out_t beat;
    beat.out_byte = b;
    beat.run_last = last;
    beat.out_frame_end = fend;
    expected_beats.push_back(beat);
  endfunction

  // Work out the output beats that one accepted input beat causes.
  function automatic void code_byte(ebsc_in_t item);
    logic [7:0] b;
    logic       fend;
    b = item.in_byte;
    fend = item.in_frame_end;
    if (mode_dir == DIR_ENCODE) begin
      case (b)
        SUB_BYTE: begin
          push_beat(ESC_BYTE, 1'b0, 1'b0);
          push_beat(ESC_SUB, 1'b1, fend);
        end
        ESC_BYTE: begin
          push_beat(ESC_BYTE, 1'b0, 1'b0);
          push_beat(ESC_BYTE, 1'b1, fend);
        end
        BYTE_1B: begin
          push_beat(ESC_BYTE, 1'b0, 1'b0);
          push_beat(ESC_1B, 1'b1, fend);
        end
        default: push_beat(b, 1'b1, fend);
      endcase
    end else if (esc_held) begin
      esc_held = 1'b0;
      case (b)
        ESC_SUB:  push_beat(SUB_BYTE, 1'b1, fend);
        ESC_BYTE: push_beat(ESC_BYTE, 1'b1, fend);
        ESC_1B:   push_beat(BYTE_1B, 1'b1, fend);
        default: begin
          // The held escape is flushed ahead of the byte.
          push_beat(ESC_BYTE, 1'b0, 1'b0);
          push_beat(b, 1'b1, fend);
        end
      endcase
    end else if (b == ESC_BYTE && !fend) begin
      esc_held = 1'b1;
    end else begin
      push_beat(b, 1'b1, fend);
    end
  endfunction

  // Compare one output beat with the oldest expected beat.
  function automatic void check_beat(ebsc_out_t got);
    ebsc_out_t want;
    if (expected_beats.size() == 0) begin
      fail_count++;
      if (mismatch_count < MAX_SHOWN)
        $display("unexpected beat: byte %h last %b fend %b",
                 got.out_byte, got.run_last, got.out_frame_end);
      mismatch_count++;
    end else begin
      want = expected_beats.pop_front();
      if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
          got.out_frame_end !== want.out_frame_end) begin
        fail_count++;
        if (mismatch_count < MAX_SHOWN)
          $display("beat mismatch: expected byte %h last %b fend %b, got byte %h last %b fend %b",
                   want.out_byte, want.run_last, want.out_frame_end,
                   got.out_byte, got.run_last, got.out_frame_end);
        mismatch_count++;
      end
    end
  endfunction

  // Watch all three channels; the predictor follows every accepted beat in order.
  always @(posedge clk) begin
    if (!rst_n) begin
      mode_dir = DIR_ENCODE;
      esc_held = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_dir = cfg_direction;
        esc_held = 1'b0;
      end
      if (in_valid && in_ready)
        code_byte(in_data);
      if (out_valid && out_ready)
        check_beat(out_data);
    end
  end

  // Send one input beat, after a random idle gap.
  task automatic send_byte(input logic [7:0] b, input logic fend);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < snd_idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{in_byte: b, in_frame_end: fend};
    do @(posedge clk); while (!in_ready);
  endtask

  // Let all expected beats drain, then idle for the DRAIN_CYCLES margin.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(input logic dir);
    cfg_valid <= 1'b1;
    cfg_direction <= dir;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random byte with a strong bias toward the escape-related codes.
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if ($urandom_range(9) < 4) begin
      case ($urandom_range(4))
        0: b = SUB_BYTE;
        1: b = ESC_BYTE;
        2: b = BYTE_1B;
        3: b = ESC_SUB;
        default: b = ESC_1B;
      endcase
    end
    return b;
  endfunction

  // Encode mode: extremes, every escaped code, and the codes that look like escapes.
  task automatic test_encode_directed();
    write_direction(DIR_ENCODE);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(SUB_BYTE, 1'b0);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(BYTE_1B, 1'b1);
    send_byte(ESC_SUB, 1'b0);
    send_byte(ESC_1B, 1'b1);
    wait_idle();
  endtask

  // Decode mode: each escape pair, a flushed escape and escapes at a frame end.
  task automatic test_decode_directed();
    write_direction(DIR_DECODE);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(ESC_SUB, 1'b0);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(ESC_1B, 1'b1);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(8'h00, 1'b0);
    // An escape that ends a frame goes out raw and is not held.
    send_byte(ESC_BYTE, 1'b1);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(SUB_BYTE, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();
  endtask

  // A direction write drops a held escape, so the next escape code passes raw.
  task automatic test_config_drops_escape();
    send_byte(ESC_BYTE, 1'b0);
    wait_idle();
    write_direction(DIR_DECODE);
    send_byte(ESC_SUB, 1'b1);
    wait_idle();
  endtask

  // Random frames in one mode under one idling pattern.
  task automatic test_random_traffic(input logic dir, input int snd_pct, input int rcv_pct,
                                     input int n_items);
    logic [7:0] stream[$];
    logic [7:0] b;
    int sent;
    int len;
    sent = 0;
    snd_idle_pct = snd_pct;
    rcv_stall_pct = rcv_pct;
    write_direction(dir);
    while (sent < n_items) begin
      stream.delete();
      len = $urandom_range(1, 12);
      repeat (len) begin
        b = pick_byte();
        // Mostly well-formed escaped data in decode mode, with some raw noise.
        if (dir == DIR_DECODE && $urandom_range(99) < 85) begin
          case (b)
            SUB_BYTE: begin stream.push_back(ESC_BYTE); stream.push_back(ESC_SUB); end
            ESC_BYTE: begin stream.push_back(ESC_BYTE); stream.push_back(ESC_BYTE); end
            BYTE_1B:  begin stream.push_back(ESC_BYTE); stream.push_back(ESC_1B); end
            default:  stream.push_back(b);
          endcase
        end else begin
          stream.push_back(b);
        end
      end
      foreach (stream[i])
        send_byte(stream[i], i == stream.size() - 1);
      sent += stream.size();
    end
    wait_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_encode_directed();
    test_decode_directed();
    test_config_drops_escape();
    test_random_traffic(DIR_ENCODE, 0, 0, 160);
    test_random_traffic(DIR_DECODE, 0, 0, 160);
    test_random_traffic(DIR_ENCODE, 88, 0, 160);
    test_random_traffic(DIR_DECODE, 88, 0, 160);
    test_random_traffic(DIR_DECODE, 0, 88, 160);
    test_random_traffic(DIR_ENCODE, 0, 88, 160);
    test_random_traffic(DIR_DECODE, 30, 30, 160);
    test_random_traffic(DIR_ENCODE, 30, 30, 160);
    if (expected_beats.size() != 0)
      fail_count++;
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/ebsc_pkg.sv
design/ebsc_core.sv
design/ebsc_outbuf.sv
design/escape_byte_stuffing_codec.sv
tb/sv/tb.sv
